FILE: src/accumulator_machine_step_top_macros.svh
// Assertion macros for the accumulator machine step block.
// Used by the checker module; no other dependencies.
`ifndef ACCUMULATOR_MACHINE_STEP_TOP_MACROS_SVH
`define ACCUMULATOR_MACHINE_STEP_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AMS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define AMS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/ams_pkg.sv
// Package for the accumulator machine step block: widths, codes and item types.
// No dependencies; imported by ams_seq, ams_alu, the top level and the checker.
`default_nettype none

package ams_pkg;

    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 7;
    localparam int MEM_WORDS = 128;
    localparam int OPC_W     = 4;
    localparam int STEP_W    = $clog2(DATA_W);

    // Instruction opcodes; codes above OPC_HALT are illegal.
    localparam logic [OPC_W-1:0] OPC_LOAD  = OPC_W'(0);
    localparam logic [OPC_W-1:0] OPC_STORE = OPC_W'(1);
    localparam logic [OPC_W-1:0] OPC_ADD   = OPC_W'(2);
    localparam logic [OPC_W-1:0] OPC_MUL   = OPC_W'(3);
    localparam logic [OPC_W-1:0] OPC_DIV   = OPC_W'(4);
    localparam logic [OPC_W-1:0] OPC_SUB   = OPC_W'(5);
    localparam logic [OPC_W-1:0] OPC_JMP   = OPC_W'(6);
    localparam logic [OPC_W-1:0] OPC_JZ    = OPC_W'(7);
    localparam logic [OPC_W-1:0] OPC_JPOS  = OPC_W'(8);
    localparam logic [OPC_W-1:0] OPC_JNEG  = OPC_W'(9);
    localparam logic [OPC_W-1:0] OPC_PRINT = OPC_W'(10);
    localparam logic [OPC_W-1:0] OPC_INPUT = OPC_W'(11);
    localparam logic [OPC_W-1:0] OPC_HALT  = OPC_W'(12);

    typedef enum logic [1:0] {
        OPN_WRITE  = 2'd0,
        OPN_SET_PC = 2'd1,
        OPN_EXEC   = 2'd2,
        OPN_NONE   = 2'd3
    } operation_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_HALTED   = 2'd1,
        ST_ILLEGAL  = 2'd2,
        ST_DIV_ZERO = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_DECODE,
        S_EXEC,
        S_ALU,
        S_RESPOND
    } state_t;

    typedef struct packed {
        operation_t               operation;
        logic [ADDR_W-1:0]        address;
        logic [OPC_W-1:0]         opcode_in;
        logic signed [DATA_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0]        pc_now;
        logic signed [DATA_W-1:0] accumulator_now;
        logic signed [DATA_W-1:0] printed_value;
        logic                     print_valid;
        status_t                  status;
    } out_item_t;

    typedef struct packed {
        logic              opc_we;
        logic              opnd_we;
        logic [ADDR_W-1:0] waddr;
        logic [OPC_W-1:0]  opc_wdata;
        logic [DATA_W-1:0] opnd_wdata;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic start;
        logic is_div;
    } alu_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] result;
    } alu_rsp_t;

endpackage

`default_nettype wire

FILE: src/ams_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module ams_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: src/ams_alu.sv
// Iterative multiply and signed divide unit, one bit per cycle.
// Depends on ams_pkg.
`default_nettype none

module ams_alu (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire ams_pkg::alu_req_t         req,
    input  wire logic [ams_pkg::DATA_W-1:0] a,
    input  wire logic [ams_pkg::DATA_W-1:0] b,
    output ams_pkg::alu_rsp_t              rsp
);
    import ams_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              div_reg, div_next;
    logic              neg_reg, neg_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    // a_reg: multiplier or dividend/quotient; b_reg: multiplicand or divisor;
    // p_reg: product or partial remainder.
    logic [DATA_W-1:0] a_reg, a_next;
    logic [DATA_W-1:0] b_reg, b_next;
    logic [DATA_W-1:0] p_reg, p_next;
    logic [DATA_W:0]   rem_sh;
    logic [DATA_W+1:0] diff;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        div_next  = div_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        p_next    = p_reg;
        rem_sh    = {p_reg, a_reg[DATA_W-1]};
        diff      = {1'b0, rem_sh} - {2'b00, b_reg};

        if (req.start) begin
            busy_next = 1'b1;
            div_next  = req.is_div;
            cnt_next  = '0;
            p_next    = '0;
            if (req.is_div) begin
                a_next   = a[DATA_W-1] ? -a : a;
                b_next   = b[DATA_W-1] ? -b : b;
                neg_next = a[DATA_W-1] ^ b[DATA_W-1];
            end else begin
                a_next   = a;
                b_next   = b;
                neg_next = 1'b0;
            end
        end else if (busy_reg) begin
            if (div_reg) begin
                if (!diff[DATA_W+1]) begin
                    p_next = diff[DATA_W-1:0];
                    a_next = {a_reg[DATA_W-2:0], 1'b1};
                end else begin
                    p_next = rem_sh[DATA_W-1:0];
                    a_next = {a_reg[DATA_W-2:0], 1'b0};
                end
            end else begin
                if (a_reg[0]) begin
                    p_next = p_reg + b_reg;
                end
                a_next = a_reg >> 1;
                b_next = b_reg << 1;
            end
            cnt_next = cnt_reg + STEP_W'(1);
            if (cnt_reg == STEP_W'(DATA_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        div_reg <= div_next;
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        p_reg   <= p_next;
    end

    always_comb begin
        rsp.done = done_reg;
        if (!div_reg) begin
            rsp.result = p_reg;
        end else if (neg_reg) begin
            rsp.result = -a_reg;
        end else begin
            rsp.result = a_reg;
        end
    end

endmodule

`default_nettype wire

FILE: src/ams_seq.sv
// Sequencer of the accumulator machine: machine state, fetch, decode and execute.
// Depends on ams_pkg; drives the memories and the shared arithmetic unit.
`default_nettype none

module ams_seq (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire ams_pkg::in_item_t          s_item,
    output ams_pkg::mem_req_t               mem_req,
    input  wire logic [ams_pkg::OPC_W-1:0]  opc_rdata,
    input  wire logic [ams_pkg::DATA_W-1:0] opnd_rdata,
    output ams_pkg::alu_req_t               alu_req,
    output logic [ams_pkg::DATA_W-1:0]      alu_a,
    output logic [ams_pkg::DATA_W-1:0]      alu_b,
    input  wire ams_pkg::alu_rsp_t          alu_rsp,
    output logic                            rsp_valid,
    output ams_pkg::out_item_t              rsp_item,
    input  wire logic                       rsp_taken
);
    import ams_pkg::*;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] pc_reg, pc_next;
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic              halted_reg, halted_next;
    logic [OPC_W-1:0]  op_reg, op_next;
    logic [ADDR_W-1:0] ea_reg, ea_next;
    logic [DATA_W-1:0] value_reg, value_next;
    logic              print_reg, print_next;
    logic [DATA_W-1:0] shown_reg, shown_next;
    status_t           status_reg, status_next;
    logic [ADDR_W-1:0] pc_inc;

    assign pc_inc = pc_reg + ADDR_W'(1);

    always_comb begin
        state_next  = state_reg;
        pc_next     = pc_reg;
        acc_next    = acc_reg;
        halted_next = halted_reg;
        op_next     = op_reg;
        ea_next     = ea_reg;
        value_next  = value_reg;
        print_next  = print_reg;
        shown_next  = shown_reg;
        status_next = status_reg;

        mem_req            = '0;
        mem_req.waddr      = ea_reg;
        mem_req.opnd_wdata = acc_reg;
        mem_req.raddr      = ea_reg;
        alu_req            = '0;
        alu_a              = acc_reg;
        alu_b              = opnd_rdata;
        s_ready            = 1'b0;
        rsp_valid          = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    value_next  = s_item.value;
                    print_next  = 1'b0;
                    shown_next  = '0;
                    status_next = ST_OK;
                    state_next  = S_RESPOND;
                    unique case (s_item.operation)
                        OPN_WRITE: begin
                            mem_req.opc_we     = 1'b1;
                            mem_req.opnd_we    = 1'b1;
                            mem_req.waddr      = s_item.address;
                            mem_req.opc_wdata  = s_item.opcode_in;
                            mem_req.opnd_wdata = s_item.value;
                        end
                        OPN_SET_PC: begin
                            pc_next     = s_item.address;
                            halted_next = 1'b0;
                        end
                        OPN_EXEC: begin
                            if (halted_reg) begin
                                status_next = ST_HALTED;
                            end else begin
                                state_next = S_FETCH;
                            end
                        end
                        OPN_NONE: begin
                        end
                    endcase
                end
            end
            S_FETCH: begin
                mem_req.raddr = pc_reg;
                state_next    = S_DECODE;
            end
            S_DECODE: begin
                // Word at the program counter is on the read ports now.
                op_next       = opc_rdata;
                ea_next       = opnd_rdata[ADDR_W-1:0];
                mem_req.raddr = opnd_rdata[ADDR_W-1:0];
                state_next    = S_EXEC;
            end
            S_EXEC: begin
                // Operand port now shows memory[ea].
                state_next = S_RESPOND;
                pc_next    = pc_inc;
                unique case (op_reg)
                    OPC_LOAD:  acc_next = opnd_rdata;
                    OPC_STORE: mem_req.opnd_we = 1'b1;
                    OPC_ADD:   acc_next = acc_reg + opnd_rdata;
                    OPC_SUB:   acc_next = acc_reg - opnd_rdata;
                    OPC_MUL: begin
                        pc_next       = pc_reg;
                        alu_req.start = 1'b1;
                        state_next    = S_ALU;
                    end
                    OPC_DIV: begin
                        pc_next = pc_reg;
                        if (opnd_rdata == '0) begin
                            status_next = ST_DIV_ZERO;
                        end else begin
                            alu_req.start  = 1'b1;
                            alu_req.is_div = 1'b1;
                            state_next     = S_ALU;
                        end
                    end
                    OPC_JMP:  pc_next = ea_reg;
                    OPC_JZ:   if (acc_reg == '0) pc_next = ea_reg;
                    OPC_JPOS: if (!acc_reg[DATA_W-1] && acc_reg != '0) pc_next = ea_reg;
                    OPC_JNEG: if (acc_reg[DATA_W-1]) pc_next = ea_reg;
                    OPC_PRINT: begin
                        print_next = 1'b1;
                        shown_next = opnd_rdata;
                    end
                    OPC_INPUT: begin
                        mem_req.opnd_we    = 1'b1;
                        mem_req.opnd_wdata = value_reg;
                    end
                    OPC_HALT: begin
                        pc_next     = pc_reg;
                        halted_next = 1'b1;
                        status_next = ST_HALTED;
                    end
                    default: begin
                        pc_next     = pc_reg;
                        status_next = ST_ILLEGAL;
                    end
                endcase
            end
            S_ALU: begin
                if (alu_rsp.done) begin
                    acc_next   = alu_rsp.result;
                    pc_next    = pc_inc;
                    state_next = S_RESPOND;
                end
            end
            S_RESPOND: begin
                rsp_valid = 1'b1;
                if (rsp_taken) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            pc_reg     <= '0;
            acc_reg    <= '0;
            halted_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            pc_reg     <= pc_next;
            acc_reg    <= acc_next;
            halted_reg <= halted_next;
        end
        op_reg     <= op_next;
        ea_reg     <= ea_next;
        value_reg  <= value_next;
        print_reg  <= print_next;
        shown_reg  <= shown_next;
        status_reg <= status_next;
    end

    always_comb begin
        rsp_item.pc_now          = pc_reg;
        rsp_item.accumulator_now = acc_reg;
        rsp_item.printed_value   = shown_reg;
        rsp_item.print_valid     = print_reg;
        rsp_item.status          = status_reg;
    end

endmodule

`default_nettype wire

FILE: src/accumulator_machine_step_top.sv
// Top level of the accumulator machine step block: sequencer, memories,
// shared multiply/divide unit and result register. Depends on ams_pkg,
// ams_seq, ams_alu and ams_ram.
//
// Usage. Each input item on s_valid/s_ready/s_item either writes one
// memory word (opcode and operand), sets the program counter and clears
// the halt flag, executes the single instruction at the program
// counter, or does nothing. Every accepted item produces exactly one
// result item on m_valid/m_ready/m_item carrying the program counter
// and accumulator after the item, any printed value and a status code.
//
// Flow. The block takes one item at a time. A memory write, a program
// counter write, an ignored operation or an execute while halted goes
// from acceptance through the respond state into the result register.
// An executed instruction goes through the fetch, decode, execute and
// respond states: fetch and operand reads go through the registered
// read port of the memories, one after the other. Multiply and a divide
// by nonzero add the ALU state, where the shared shift-and-add /
// restoring divide unit retires one bit per cycle over 32 bits.
//
// Reset (aresetn low, synchronous) clears the program counter, the
// accumulator, the halt flag and all handshake state; memory contents
// are undefined until written. When the receiver stalls, the finished
// result waits in the output register and the block holds its next
// result in the sequencer until the register is free, taking no item.
`default_nettype none

module accumulator_machine_step_top (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire ams_pkg::in_item_t  s_item,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output ams_pkg::out_item_t      m_item
);
    import ams_pkg::*;

    mem_req_t          mem_req;
    alu_req_t          alu_req;
    alu_rsp_t          alu_rsp;
    logic [DATA_W-1:0] alu_a;
    logic [DATA_W-1:0] alu_b;
    logic [OPC_W-1:0]  opc_rdata;
    logic [DATA_W-1:0] opnd_rdata;
    logic              rsp_valid;
    out_item_t         rsp_item;
    logic              rsp_taken;

    // Result register: the sequencer's result moves in whenever the
    // register is empty or its item is being taken in the same cycle.
    logic      m_valid_reg, m_valid_next;
    out_item_t m_item_reg, m_item_next;

    ams_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .mem_req    (mem_req),
        .opc_rdata  (opc_rdata),
        .opnd_rdata (opnd_rdata),
        .alu_req    (alu_req),
        .alu_a      (alu_a),
        .alu_b      (alu_b),
        .alu_rsp    (alu_rsp),
        .rsp_valid  (rsp_valid),
        .rsp_item   (rsp_item),
        .rsp_taken  (rsp_taken)
    );

    ams_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .a       (alu_a),
        .b       (alu_b),
        .rsp     (alu_rsp)
    );

    // Opcode half of each memory word.
    ams_ram #(
        .WIDTH (OPC_W),
        .DEPTH (MEM_WORDS)
    ) u_opc_ram (
        .aclk  (aclk),
        .we    (mem_req.opc_we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.opc_wdata),
        .raddr (mem_req.raddr),
        .rdata (opc_rdata)
    );

    // Operand half of each memory word; also the data memory.
    ams_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MEM_WORDS)
    ) u_opnd_ram (
        .aclk  (aclk),
        .we    (mem_req.opnd_we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.opnd_wdata),
        .raddr (mem_req.raddr),
        .rdata (opnd_rdata)
    );

    assign rsp_taken = rsp_valid && (!m_valid_reg || m_ready);

    always_comb begin
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;
        if (rsp_taken) begin
            m_valid_next = 1'b1;
            m_item_next  = rsp_item;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

`default_nettype wire

FILE: src/ams_checker.sv
// Port-level checker for the accumulator machine step block, with its bind.
// Depends on ams_pkg and accumulator_machine_step_top_macros.svh.
`default_nettype none

`include "accumulator_machine_step_top_macros.svh"

module ams_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire ams_pkg::in_item_t  s_item,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire ams_pkg::out_item_t m_item
);
    import ams_pkg::*;

    // One item at a time: taking an item drops ready for the next cycle.
    `AMS_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_valid && s_ready, !s_ready, "ready stayed high after an item was taken")

    // A result with no print shows zero as the printed value.
    `AMS_ASSERT_NOW(a_print_zero, aclk, aresetn, m_valid && !m_item.print_valid, m_item.printed_value == '0, "printed value set without a print")

    // A print is only reported by an instruction that completed normally.
    `AMS_ASSERT_NOW(a_print_ok, aclk, aresetn, m_valid && m_item.print_valid, m_item.status == ST_OK, "print reported with a failing status")

    // A stalled result holds.
    `AMS_ASSERT_NEXT(a_hold_result, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_item), "result changed while stalled")

endmodule

bind accumulator_machine_step_top ams_checker u_ams_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_item  (s_item),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

`default_nettype wire
